FILE: src/rtt_pkg.sv
// shared types and constants for the restartable timeout table
// no dependencies
`timescale 1ns / 1ps

package rtt_pkg;

	localparam int SLOT_W      = 4;
	localparam int CMD_W       = 2;
	localparam int DUR_IN_W    = 32;
	localparam int QUEUE_DEPTH = 2;

	typedef logic [SLOT_W-1:0] slot_t;

	typedef enum logic [CMD_W-1:0] {
		OP_ADD     = 2'd0,
		OP_REFRESH = 2'd1,
		OP_REMOVE  = 2'd2,
		OP_TICK    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_UNUSED = 2'd2
	} status_t;

	typedef enum logic {
		KIND_REPLY  = 1'b0,
		KIND_EXPIRY = 1'b1
	} kind_t;

	// classified request handed from front to back
	typedef struct packed {
		op_t   op;
		slot_t handle;
		logic  handle_ok;
	} cmd_t;

	typedef struct packed {
		kind_t   kind;
		slot_t   slot;
		status_t status;
		logic    last;
	} result_t;

endpackage

FILE: src/restartable_timeout_table.sv
// top level of the restartable timeout table: front stage, request queue, back end
// depends on rtt_pkg, rtt_front, rtt_queue, rtt_back, rtt_ram
`timescale 1ns / 1ps

// a table of NUM_SLOTS one-shot timeouts counted in ticks. each request is add,
// refresh, remove or tick. add claims the lowest free slot and answers with it
// (or reports a full table), refresh reloads a slot's countdown from its stored
// duration, remove frees a slot; refresh or remove of a free or out-of-range
// handle answers "not in use". a tick sweeps the whole table: slots already at
// zero send an expiry and are freed, in ascending order, with last set on the
// highest one; the rest count down by one. a tick with no expiries sends nothing.
// timing: a request is registered in the front stage and passes through a
// two-entry queue, so new requests are taken while the back end is busy. the back
// end takes a request while idle; after that add scans the in-use bits one
// slot per cycle, refresh does one read of the duration ram, and a tick
// visits each slot once through the single read port of the remaining-count ram.
// a stalled result port holds the back end; no clearing pass follows reset since
// count ram values are only used for slots that add has written

module restartable_timeout_table
	import rtt_pkg::*;
#(
	parameter int NUM_SLOTS  = 16,
	parameter int COUNT_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [CMD_W-1:0]    command,
	input  logic [SLOT_W-1:0]   handle,
	input  logic [DUR_IN_W-1:0] duration_ticks,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                kind,
	output logic [SLOT_W-1:0]   slot,
	output logic [1:0]          status,
	output logic                last
);

	localparam int Q_W = $bits(cmd_t) + COUNT_BITS;

	// front to queue
	logic                  f_valid;
	logic                  f_ready;
	cmd_t                  f_cmd;
	logic [COUNT_BITS-1:0] f_dur;

	// queue to back
	logic                  q_valid;
	logic                  q_ready;
	logic [Q_W-1:0]        q_data;
	cmd_t                  q_cmd;
	logic [COUNT_BITS-1:0] q_dur;

	result_t               res;

	rtt_front #(
		.NUM_SLOTS (NUM_SLOTS),
		.COUNT_BITS(COUNT_BITS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.command       (command),
		.handle        (handle),
		.duration_ticks(duration_ticks),
		.cmd_valid     (f_valid),
		.cmd_ready     (f_ready),
		.cmd           (f_cmd),
		.dur           (f_dur)
	);

	rtt_queue #(
		.WIDTH(Q_W)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_valid(f_valid),
		.wr_ready(f_ready),
		.wr_data ({f_cmd, f_dur}),
		.rd_valid(q_valid),
		.rd_ready(q_ready),
		.rd_data (q_data)
	);

	assign {q_cmd, q_dur} = q_data;

	rtt_back #(
		.NUM_SLOTS (NUM_SLOTS),
		.COUNT_BITS(COUNT_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(q_valid),
		.cmd_ready(q_ready),
		.cmd      (q_cmd),
		.dur      (q_dur),
		.res_valid(out_valid),
		.res_ready(out_ready),
		.res      (res)
	);

	// result fields straight from the back end's output register
	assign kind   = res.kind;
	assign slot   = res.slot;
	assign status = res.status;
	assign last   = res.last;

endmodule

FILE: src/rtt_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module rtt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: src/rtt_front.sv
// front stage: accepts requests, checks the handle range and sizes the duration
// depends on rtt_pkg
`timescale 1ns / 1ps

module rtt_front
	import rtt_pkg::*;
#(
	parameter int NUM_SLOTS  = 16,
	parameter int COUNT_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [CMD_W-1:0]      command,
	input  logic [SLOT_W-1:0]     handle,
	input  logic [DUR_IN_W-1:0]   duration_ticks,
	output logic                  cmd_valid,
	input  logic                  cmd_ready,
	output cmd_t                  cmd,
	output logic [COUNT_BITS-1:0] dur
);

	logic                  valid_s1;
	cmd_t                  cmd_s1;
	logic [COUNT_BITS-1:0] dur_s1;

	assign in_ready = !valid_s1 || cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			cmd_s1   <= '0;
			dur_s1   <= '0;
		end else begin
			if (in_valid && in_ready) begin
				valid_s1         <= 1'b1;
				cmd_s1.op        <= op_t'(command);
				cmd_s1.handle    <= handle;
				// handles past the table act as free slots
				cmd_s1.handle_ok <= (32'(handle) < 32'(NUM_SLOTS));
				dur_s1           <= COUNT_BITS'(duration_ticks);
			end else if (cmd_ready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	assign cmd_valid = valid_s1;
	assign cmd       = cmd_s1;
	assign dur       = dur_s1;

endmodule

FILE: src/rtt_queue.sv
// short request queue between front and back
// depends on rtt_pkg
`timescale 1ns / 1ps

module rtt_queue
	import rtt_pkg::*;
#(
	parameter int WIDTH = 40
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_ready,
	input  logic [WIDTH-1:0] wr_data,
	output logic             rd_valid,
	input  logic             rd_ready,
	output logic [WIDTH-1:0] rd_data
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign wr_ready = (count_q != CNT_W'(QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;
	assign rd_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
			for (int i = 0; i < QUEUE_DEPTH; i++) begin
				mem_q[i] <= '0;
			end
		end else begin
			if (push) begin
				mem_q[wr_ptr_q] <= wr_data;
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: src/rtt_back.sv
// back end: owns the slot table, runs add scans, refresh, remove and tick sweeps
// depends on rtt_pkg and rtt_ram
`timescale 1ns / 1ps

module rtt_back
	import rtt_pkg::*;
#(
	parameter int NUM_SLOTS  = 16,
	parameter int COUNT_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_ready,
	input  cmd_t                  cmd,
	input  logic [COUNT_BITS-1:0] dur,
	output logic                  res_valid,
	input  logic                  res_ready,
	output result_t               res
);

	localparam int IDX_BITS = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CNT_W    = IDX_BITS + 1;
	localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(NUM_SLOTS);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADD,
		S_CMD,
		S_REFRESH,
		S_TICK
	} state_t;

	state_t                state_q;
	cmd_t                  cmd_q;
	logic [COUNT_BITS-1:0] dur_q;
	logic [NUM_SLOTS-1:0]  in_use_q;
	logic [CNT_W-1:0]      scan_cnt_q;
	logic                  rd_valid_s1;
	logic [IDX_BITS-1:0]   idx_s1;
	logic                  pend_q;
	logic [IDX_BITS-1:0]   pend_idx_q;
	logic                  out_valid_q;
	result_t               out_q;

	logic                  out_free;
	logic [IDX_BITS-1:0]   cur_idx;
	logic                  cur_used;
	logic [IDX_BITS-1:0]   scan_idx;
	logic                  tick_hit;
	logic                  tick_stall;
	logic                  emit;
	result_t               emit_res;
	logic                  dur_we;
	logic                  dur_re;
	logic [COUNT_BITS-1:0] dur_rdata;
	logic                  rem_we;
	logic [IDX_BITS-1:0]   rem_waddr;
	logic [COUNT_BITS-1:0] rem_wdata;
	logic                  rem_re;
	logic [COUNT_BITS-1:0] rem_rdata;

	rtt_ram #(
		.WIDTH(COUNT_BITS),
		.DEPTH(NUM_SLOTS)
	) u_dur_ram (
		.clk  (clk),
		.we   (dur_we),
		.waddr(scan_idx),
		.wdata(dur_q),
		.re   (dur_re),
		.raddr(cur_idx),
		.rdata(dur_rdata)
	);

	rtt_ram #(
		.WIDTH(COUNT_BITS),
		.DEPTH(NUM_SLOTS)
	) u_rem_ram (
		.clk  (clk),
		.we   (rem_we),
		.waddr(rem_waddr),
		.wdata(rem_wdata),
		.re   (rem_re),
		.raddr(scan_idx),
		.rdata(rem_rdata)
	);

	assign out_free   = !out_valid_q || res_ready;
	assign cur_idx    = IDX_BITS'(cmd_q.handle);
	assign cur_used   = cmd_q.handle_ok && in_use_q[cur_idx];
	assign scan_idx   = scan_cnt_q[IDX_BITS-1:0];
	assign tick_hit   = rd_valid_s1 && in_use_q[idx_s1] && (rem_rdata == '0);
	// a second expiry cannot retire while the held one has nowhere to go
	assign tick_stall = tick_hit && pend_q && !out_free;
	assign cmd_ready  = (state_q == S_IDLE);

	always_comb begin
		emit      = 1'b0;
		emit_res  = '{kind: KIND_REPLY, slot: '0, status: ST_OK, last: 1'b1};
		dur_we    = 1'b0;
		dur_re    = 1'b0;
		rem_we    = 1'b0;
		rem_waddr = scan_idx;
		rem_wdata = dur_q;
		rem_re    = 1'b0;
		case (state_q)
			S_ADD: begin
				if (scan_cnt_q == SCAN_END) begin
					if (out_free) begin
						emit            = 1'b1;
						emit_res.status = ST_FULL;
					end
				end else if (!in_use_q[scan_idx] && out_free) begin
					emit          = 1'b1;
					emit_res.slot = SLOT_W'(scan_idx);
					dur_we        = 1'b1;
					rem_we        = 1'b1;
				end
			end
			S_CMD: begin
				if (out_free) begin
					if (!cur_used) begin
						emit            = 1'b1;
						emit_res.slot   = cmd_q.handle;
						emit_res.status = ST_UNUSED;
					end else if (cmd_q.op == OP_REMOVE) begin
						emit          = 1'b1;
						emit_res.slot = cmd_q.handle;
					end else begin
						dur_re = 1'b1;
					end
				end
			end
			S_REFRESH: begin
				if (out_free) begin
					emit          = 1'b1;
					emit_res.slot = cmd_q.handle;
					rem_we        = 1'b1;
					rem_waddr     = cur_idx;
					rem_wdata     = dur_rdata;
				end
			end
			S_TICK: begin
				if (!tick_stall) begin
					if (tick_hit && pend_q) begin
						emit = 1'b1;
						emit_res = '{kind: KIND_EXPIRY, slot: SLOT_W'(pend_idx_q),
							status: ST_OK, last: 1'b0};
					end
					if (rd_valid_s1 && !tick_hit && in_use_q[idx_s1]) begin
						rem_we    = 1'b1;
						rem_waddr = idx_s1;
						rem_wdata = rem_rdata - 1'b1;
					end
					if (scan_cnt_q != SCAN_END) begin
						rem_re = 1'b1;
					end else if (!rd_valid_s1 && pend_q && out_free) begin
						emit = 1'b1;
						emit_res = '{kind: KIND_EXPIRY, slot: SLOT_W'(pend_idx_q),
							status: ST_OK, last: 1'b1};
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cmd_q       <= '0;
			dur_q       <= '0;
			in_use_q    <= '0;
			scan_cnt_q  <= '0;
			rd_valid_s1 <= 1'b0;
			idx_s1      <= '0;
			pend_q      <= 1'b0;
			pend_idx_q  <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
				out_q       <= emit_res;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						cmd_q       <= cmd;
						dur_q       <= dur;
						scan_cnt_q  <= '0;
						rd_valid_s1 <= 1'b0;
						pend_q      <= 1'b0;
						case (cmd.op)
							OP_ADD:  state_q <= S_ADD;
							OP_TICK: state_q <= S_TICK;
							default: state_q <= S_CMD;
						endcase
					end
				end
				S_ADD: begin
					if (scan_cnt_q == SCAN_END) begin
						if (out_free) begin
							state_q <= S_IDLE;
						end
					end else if (!in_use_q[scan_idx]) begin
						if (out_free) begin
							in_use_q[scan_idx] <= 1'b1;
							state_q            <= S_IDLE;
						end
					end else begin
						scan_cnt_q <= scan_cnt_q + 1'b1;
					end
				end
				S_CMD: begin
					if (out_free) begin
						if (!cur_used) begin
							state_q <= S_IDLE;
						end else if (cmd_q.op == OP_REMOVE) begin
							in_use_q[cur_idx] <= 1'b0;
							state_q           <= S_IDLE;
						end else begin
							state_q <= S_REFRESH;
						end
					end
				end
				S_REFRESH: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_TICK: begin
					if (!tick_stall) begin
						if (tick_hit) begin
							in_use_q[idx_s1] <= 1'b0;
							pend_q           <= 1'b1;
							pend_idx_q       <= idx_s1;
						end
						if (scan_cnt_q != SCAN_END) begin
							rd_valid_s1 <= 1'b1;
							idx_s1      <= scan_idx;
							scan_cnt_q  <= scan_cnt_q + 1'b1;
						end else begin
							rd_valid_s1 <= 1'b0;
							if (!rd_valid_s1 && (!pend_q || out_free)) begin
								state_q <= S_IDLE;
							end
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

endmodule
